// File: rtl/lsmb_pkg.sv
// Shared types and constants for the lidar sector minimum binning block.
// Depends on nothing; imported by every module under rtl/.
`default_nettype none

package lsmb_pkg;

    localparam int NUM_BINS    = 91;
    localparam int BIN_W       = 7;
    localparam int DIST_W      = 17;
    localparam int DEG_W       = 9;
    localparam int IDX_W       = 13;
    localparam int RANGE_W     = 16;
    localparam int START_W     = 26;
    localparam int STEP_W      = 21;
    localparam int PROD_W      = STEP_W + IDX_W;
    localparam int ANGLE_W     = 36;
    localparam int MAX_SAMPLES = 8192;

    localparam logic [DIST_W-1:0] INF_CODE = 17'h10000;

    // Angles in signed Q16 degrees
    localparam logic signed [ANGLE_W-1:0] DEG360_Q = 36'sd23592960;
    localparam logic signed [ANGLE_W-1:0] DEG315_Q = 36'sd20643840;
    localparam logic signed [ANGLE_W-1:0] DEG45_Q  = 36'sd2949120;

    localparam logic [DEG_W-1:0] DEG_WRAP = 9'd360;
    localparam logic [DEG_W-1:0] DEG_315  = 9'd315;
    localparam logic [DEG_W-1:0] DEG_45   = 9'd45;
    localparam logic [BIN_W-1:0] BIN_WRAP = 7'd45;
    localparam logic [BIN_W-1:0] BIN_LAST = 7'd90;

    // Register indexes of the configuration port
    localparam logic CFG_ANGLE_START = 1'b0;
    localparam logic CFG_ANGLE_STEP  = 1'b1;

    localparam logic [START_W-1:0] START_RESET = 26'd0;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 21'd65536;

    // Item kinds carried on tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [BIN_W-1:0] bin;
    } ang_res_t;

    typedef struct packed {
        logic             clear;
        logic             rd_en;
        logic             wr_en;
        logic [BIN_W-1:0] addr;
    } mem_req_t;

endpackage

`default_nettype wire

// File: rtl/lsmb_angle.sv
// Three-stage angle unit: multiply, offset, normalize and map to a bin.
// Depends on lsmb_pkg.
`default_nettype none

module lsmb_angle
    import lsmb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [IDX_W-1:0]   idx,
    input  wire logic [START_W-1:0] angle_start,
    input  wire logic [STEP_W-1:0]  angle_step,
    output ang_res_t                res
);

    logic                      s1_valid_reg;
    logic                      s2_valid_reg;
    logic                      s3_valid_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      idx_ok1_reg;
    logic                      idx_ok2_reg;
    logic signed [ANGLE_W-1:0] sum_reg;
    logic                      hit_reg;
    logic [BIN_W-1:0]          bin_reg;

    logic signed [ANGLE_W-1:0] start_ext;
    logic signed [ANGLE_W-1:0] prod_ext;
    logic signed [ANGLE_W-1:0] plus_a;
    logic signed [ANGLE_W-1:0] minus_a;
    logic signed [ANGLE_W-1:0] norm_a;
    logic                      in_sector;
    logic [DEG_W:0]            deg_raw;
    logic [DEG_W-1:0]          deg;
    logic [BIN_W-1:0]          bin;

    assign start_ext = {{(ANGLE_W-START_W){angle_start[START_W-1]}}, angle_start};
    assign prod_ext  = {{(ANGLE_W-PROD_W){1'b0}}, prod_reg};

    // Both corrections in parallel, then pick one
    always_comb
    begin
        plus_a  = sum_reg + DEG360_Q;
        minus_a = sum_reg - DEG360_Q;
        if (sum_reg < 0)
            norm_a = plus_a;
        else if (sum_reg >= DEG360_Q)
            norm_a = minus_a;
        else
            norm_a = sum_reg;

        in_sector = (norm_a >= DEG315_Q && norm_a < DEG360_Q)
                 || (norm_a >= 0 && norm_a <= DEG45_Q);

        // Round half up to whole degrees, wrap 360 to 0
        deg_raw = {1'b0, norm_a[24:16]} + {{DEG_W{1'b0}}, norm_a[15]};
        if (deg_raw == {1'b0, DEG_WRAP})
            deg = '0;
        else
            deg = deg_raw[DEG_W-1:0];

        if (deg >= DEG_315)
            bin = BIN_W'(deg - DEG_315);
        else
            bin = BIN_W'(deg + DEG_45);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg    <= PROD_W'(angle_step) * PROD_W'(idx);
            idx_ok1_reg <= (17'(idx) < 17'(MAX_SAMPLES));
        end
        if (s1_valid_reg)
        begin
            sum_reg     <= start_ext + prod_ext;
            idx_ok2_reg <= idx_ok1_reg;
        end
        if (s2_valid_reg)
        begin
            hit_reg <= idx_ok2_reg && in_sector;
            bin_reg <= bin;
        end
    end

    assign res.valid = s3_valid_reg;
    assign res.hit   = hit_reg;
    assign res.bin   = bin_reg;

endmodule

`default_nettype wire

// File: rtl/lsmb_bin_mem.sv
// Bin minimum memory with registered read and per-bin filled flags.
// Depends on lsmb_pkg.
`default_nettype none

module lsmb_bin_mem
    import lsmb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mem_req_t          req,
    input  wire logic [DIST_W-1:0] wr_data,
    output logic [DIST_W-1:0]      rd_data,
    output logic                   rd_filled
);

    logic [DIST_W-1:0]   bin_min_reg [0:NUM_BINS-1];
    logic [NUM_BINS-1:0] filled_reg;
    logic [DIST_W-1:0]   rd_data_reg;
    logic                rd_filled_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            bin_min_reg[req.addr] <= wr_data;
        if (req.rd_en)
            rd_data_reg <= bin_min_reg[req.addr];
    end

    // Clear drops every flag at once; a write marks its bin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= '0;
            rd_filled_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
                filled_reg <= '0;
            else if (req.wr_en)
                filled_reg[req.addr] <= 1'b1;
            if (req.rd_en)
                rd_filled_reg <= filled_reg[req.addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign rd_filled = rd_filled_reg;

endmodule

`default_nettype wire

// File: rtl/lidar_sector_min_binning.sv
// Lidar sector minimum binning: shortest range per degree, 315..359 and 0..45.
// Sample item: angle unit, then a bin read and an update; the read and update are
// skipped when the sample falls outside the sector or its index is too large.
// Read item: a bin read, then the result goes to the output register, held back
// while that register is stalled. One item is in work at a time.
// Reset clears config to start 0 / step 1.0 degree and all bins to empty.
`default_nettype none

module lidar_sector_min_binning
    import lsmb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write port
    input  wire logic               cfg_we,
    input  wire logic               cfg_addr,
    input  wire logic [START_W-1:0] cfg_wdata,
    // input item stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // [0] first_of_scan, [13:1] sample_index, [29:14] range_mm,
    // [30] no_return, [37:31] bin_index, [39:38] zero
    input  wire logic [39:0]        s_tdata,
    // [0] command
    input  wire logic               s_tuser,
    // result item stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [16:0] distance_mm, [25:17] angle_deg, [31:26] zero
    output logic [31:0]             m_tdata,
    // last_bin
    output logic                    m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ANGLE = 3'd1;
    localparam logic [2:0] ST_SREAD = 3'd2;
    localparam logic [2:0] ST_SUPD  = 3'd3;
    localparam logic [2:0] ST_RREAD = 3'd4;
    localparam logic [2:0] ST_ROUT  = 3'd5;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;

    logic [START_W-1:0] angle_start_reg;
    logic [STEP_W-1:0]  angle_step_reg;

    logic [BIN_W-1:0]   addr_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               in_range_reg;

    logic               m_tvalid_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic [DEG_W-1:0]   out_angle_reg;
    logic               out_last_reg;

    // input field unpacking
    logic               in_cmd;
    logic               in_first;
    logic [IDX_W-1:0]   in_idx;
    logic [RANGE_W-1:0] in_range;
    logic               in_noret;
    logic [BIN_W-1:0]   in_bin;

    logic               accept;
    logic               out_free;
    logic               out_load;
    ang_res_t           ang_res;
    mem_req_t           mem_req;
    logic [DIST_W-1:0]  rd_data;
    logic               rd_filled;
    logic [DEG_W-1:0]   read_angle;

    assign in_cmd   = s_tuser;
    assign in_first = s_tdata[0];
    assign in_idx   = s_tdata[13:1];
    assign in_range = s_tdata[29:14];
    assign in_noret = s_tdata[30];
    assign in_bin   = s_tdata[37:31];

    // Take a new item only when the previous one has left the datapath;
    // a finished result may still wait in the output register.
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_ROUT) && out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= START_RESET;
            angle_step_reg  <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ANGLE_START: angle_start_reg <= cfg_wdata;
                CFG_ANGLE_STEP:  angle_step_reg  <= cfg_wdata[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sequencer: sample items go through the angle unit, then
    // read-modify-write one bin; read items read one bin and emit.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (in_cmd == CMD_READ) ? ST_RREAD : ST_ANGLE;
            end
            ST_ANGLE:
            begin
                if (ang_res.valid)
                    state_next = ang_res.hit ? ST_SREAD : ST_IDLE;
            end
            ST_SREAD: state_next = ST_SUPD;
            ST_SUPD:  state_next = ST_IDLE;
            ST_RREAD: state_next = ST_ROUT;
            ST_ROUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Item payload: bin address, effective distance, read range check
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg     <= in_bin;
            in_range_reg <= (in_bin < BIN_W'(NUM_BINS));
            if (in_range == '0 || in_noret)
                dist_reg <= INF_CODE;
            else
                dist_reg <= {1'b0, in_range};
        end
        else if (state_reg == ST_ANGLE && ang_res.valid && ang_res.hit)
        begin
            addr_reg <= ang_res.bin;
        end
    end

    lsmb_angle u_angle (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept && in_cmd == CMD_SAMPLE),
        .idx         (in_idx),
        .angle_start (angle_start_reg),
        .angle_step  (angle_step_reg),
        .res         (ang_res)
    );

    // Memory access. Items never overlap, so the update always sees the
    // value it just read; first_of_scan drops all filled flags on accept.
    always_comb
    begin
        mem_req.clear = accept && in_first;
        mem_req.rd_en = (state_reg == ST_SREAD)
                     || (state_reg == ST_RREAD && in_range_reg);
        mem_req.wr_en = (state_reg == ST_SUPD) && (!rd_filled || dist_reg < rd_data);
        mem_req.addr  = addr_reg;
    end

    lsmb_bin_mem u_bin_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mem_req),
        .wr_data   (dist_reg),
        .rd_data   (rd_data),
        .rd_filled (rd_filled)
    );

    // Bin 0 is 315 degrees, bin 45 is 0 degrees
    always_comb
    begin
        if (!in_range_reg)
            read_angle = '0;
        else if (addr_reg < BIN_WRAP)
            read_angle = DEG_315 + DEG_W'(addr_reg);
        else
            read_angle = DEG_W'(addr_reg) - DEG_45;
    end

    // Output register: hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_dist_reg  <= (in_range_reg && rd_filled) ? rd_data : INF_CODE;
            out_angle_reg <= read_angle;
            out_last_reg  <= in_range_reg && (addr_reg == BIN_LAST);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_angle_reg, out_dist_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_wr_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> $past(state_reg) == ST_SREAD)
        else $error("bin write without preceding read");

    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_ROUT)
        else $error("result raised outside a read item");

    a_angle_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        ang_res.valid |-> state_reg == ST_ANGLE)
        else $error("angle result outside angle wait");

    a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ang_res.valid && ang_res.hit |-> ang_res.bin <= BIN_LAST)
        else $error("angle unit produced bin beyond 45 degrees");
`endif

endmodule

`default_nettype wire

// File: sim/lsmb_checker.sv
// Checker for the sector binning block: tracks configuration writes and accepted items,
// predicts every read report and compares it field by field with the result stream.
// Depends on lsmb_pkg for widths, command and register codes and the Q16 angle constants.
`timescale 1ns / 1ps

module lsmb_checker
    import lsmb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [START_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    input  logic               s_tready,
    // [0] first_of_scan, [13:1] sample_index, [29:14] range_mm,
    // [30] no_return, [37:31] bin_index, [39:38] zero
    input  logic [39:0]        s_tdata,
    // [0] command
    input  logic               s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    // [16:0] distance_mm, [25:17] angle_deg, [31:26] zero
    input  logic [31:0]        m_tdata,
    // last_bin
    input  logic               m_tlast,
    output int                 error_count,
    output int                 reports_pending
);

    localparam int REPORT_LIMIT = 10;
    localparam logic signed [ANGLE_W-1:0] HALF_DEG_Q = 36'sd32768;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [DEG_W-1:0]  angle;
        logic              last;
    } bin_report_t;

    logic [START_W-1:0] start_q16;
    logic [STEP_W-1:0]  step_q16;
    logic [DIST_W-1:0]  shortest [NUM_BINS];
    logic               occupied [NUM_BINS];
    bin_report_t        expected_reports [$];
    int                 errors_seen;

    // Bin hit by a sample, or -1 when its angle misses the forward sector.
    function automatic int sector_bin(input logic [IDX_W-1:0] idx);
        logic signed [ANGLE_W-1:0] ang;
        int deg;
        ang = {{(ANGLE_W-START_W){start_q16[START_W-1]}}, start_q16}
            + {{(ANGLE_W-PROD_W){1'b0}}, PROD_W'(step_q16) * PROD_W'(idx)};
        // one add, then one subtract; anything still out of [0,360) misses below
        if (ang < 0)
            ang = ang + DEG360_Q;
        if (ang >= DEG360_Q)
            ang = ang - DEG360_Q;
        if (!((ang >= DEG315_Q && ang < DEG360_Q) || (ang >= 0 && ang <= DEG45_Q)))
            return -1;
        deg = int'((ang + HALF_DEG_Q) >>> 16);
        if (deg >= int'(DEG_WRAP))
            deg = deg - int'(DEG_WRAP);
        return (deg >= int'(DEG_315)) ? deg - int'(DEG_315) : deg + int'(DEG_45);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bin_report_t       want;
        bin_report_t       seen;
        logic              fos;
        logic [IDX_W-1:0]  idx;
        logic [RANGE_W-1:0] rng;
        logic              noret;
        logic [BIN_W-1:0]  bin_sel;
        logic [DIST_W-1:0] sample_dist;
        int                b;
        if (!rst_n)
        begin
            start_q16 = START_RESET;
            step_q16  = STEP_RESET;
            for (int i = 0; i < NUM_BINS; i++)
                occupied[i] = 1'b0;
            expected_reports.delete();
            errors_seen = 0;
            error_count <= 0;
            reports_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_ANGLE_START)
                    start_q16 = cfg_wdata;
                else if (cfg_addr == CFG_ANGLE_STEP)
                    step_q16 = cfg_wdata[STEP_W-1:0];
            end

            if (m_tvalid && m_tready)
            begin
                seen.distance = m_tdata[DIST_W-1:0];
                seen.angle    = m_tdata[DIST_W+DEG_W-1:DIST_W];
                seen.last     = m_tlast;
                if (expected_reports.size() == 0)
                begin
                    errors_seen++;
                    if (errors_seen <= REPORT_LIMIT)
                        $display("%0t: unexpected report dist %0d angle %0d last %0d",
                                 $realtime, seen.distance, seen.angle, seen.last);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (seen.distance !== want.distance || seen.angle !== want.angle
                        || seen.last !== want.last)
                    begin
                        errors_seen++;
                        if (errors_seen <= REPORT_LIMIT)
                            $display({"%0t: report mismatch: expected dist %0d angle %0d",
                                      " last %0d, got dist %0d angle %0d last %0d"},
                                     $realtime, want.distance, want.angle, want.last,
                                     seen.distance, seen.angle, seen.last);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                fos     = s_tdata[0];
                idx     = s_tdata[13:1];
                rng     = s_tdata[29:14];
                noret   = s_tdata[30];
                bin_sel = s_tdata[37:31];
                // start of scan empties every bin, for reads too
                if (fos)
                    for (int i = 0; i < NUM_BINS; i++)
                        occupied[i] = 1'b0;
                if (s_tuser == CMD_SAMPLE)
                begin
                    b = sector_bin(idx);
                    sample_dist = (rng == '0 || noret) ? INF_CODE : {1'b0, rng};
                    if (b >= 0)
                    begin
                        if (!occupied[b] || sample_dist < shortest[b])
                        begin
                            shortest[b] = sample_dist;
                            occupied[b] = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (bin_sel >= BIN_W'(NUM_BINS))
                    begin
                        want.distance = INF_CODE;
                        want.angle    = '0;
                        want.last     = 1'b0;
                    end
                    else
                    begin
                        want.distance = occupied[bin_sel] ? shortest[bin_sel] : INF_CODE;
                        want.angle    = (bin_sel < BIN_WRAP) ? DEG_315 + DEG_W'(bin_sel)
                                                             : DEG_W'(bin_sel - BIN_WRAP);
                        want.last     = (bin_sel == BIN_LAST);
                    end
                    expected_reports.push_back(want);
                end
            end

            error_count <= errors_seen;
            reports_pending <= expected_reports.size();
        end
    end

endmodule

// File: sim/testbench.sv
// Top of the sector binning testbench: clock, reset, configuration and item stimulus,
// result back-pressure, a stall watchdog and the verdict.
// Depends on lsmb_pkg, the lidar_sector_min_binning RTL and lsmb_checker.
`timescale 1ns / 1ps

module testbench;
    import lsmb_pkg::*;

    localparam int GAP_MAX        = 12;
    // a sample item yields nothing and may still be in work after the last report
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 160;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_addr  = CFG_ANGLE_START;
    logic [START_W-1:0] cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata   = '0;
    logic               s_tuser   = CMD_SAMPLE;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [31:0]        m_tdata;
    logic               m_tlast;

    int error_count;
    int reports_pending;
    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    int holds_asked  = 0;
    int holds_taken  = 0;
    int stall_cycles = 0;

    always #2 clk = ~clk;

    lidar_sector_min_binning DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    lsmb_checker bin_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .error_count     (error_count),
        .reports_pending (reports_pending)
    );

    // Offer one item, after a random gap when tx_idle is set, and hold it until accepted.
    // Leave tvalid high on return so back-to-back items need no extra edge.
    task automatic send_item(input logic cmd, input logic fos, input logic [IDX_W-1:0] idx,
                             input logic [RANGE_W-1:0] rng, input logic noret,
                             input logic [BIN_W-1:0] bin_sel);
        int gap;
        gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, bin_sel, noret, rng, idx, fos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_sample(input logic fos, input logic [IDX_W-1:0] idx,
                               input logic [RANGE_W-1:0] rng, input logic noret);
        send_item(CMD_SAMPLE, fos, idx, rng, noret, '0);
    endtask

    task automatic send_read(input logic fos, input logic [BIN_W-1:0] bin_sel);
        send_item(CMD_READ, fos, '0, '0, 1'b0, bin_sel);
    endtask

    // Stop offering, drain every pending report, then let a trailing sample finish.
    // The opening wait makes sure the checker has booked the last accepted read.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (reports_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [START_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_addr  <= reg_sel;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: draw a stall before every item when rx_idle is set, or take a long
    // hold-off when the stimulus asks for one so the block backs up into its input.
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (holds_taken < holds_asked)
            begin
                gap = HOLD_CYCLES;
                holds_taken++;
            end
            else
                gap = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Count cycles with no handshake on either stream; give up on a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int               start_val;
        int               step_val;
        int               span;
        int               scan_pos;
        int               pick;
        bit               new_scan;
        logic             fos;
        logic [RANGE_W-1:0] rng;
        logic [BIN_W-1:0] bin_sel;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset config: sample n sits at n degrees.
        send_sample(1'b1, 13'd0, 16'd100, 1'b0);     // 0 deg
        send_sample(1'b0, 13'd0, 16'd50, 1'b0);      // smaller, replaces
        send_sample(1'b0, 13'd45, 16'hFFFF, 1'b0);   // top edge of sector, widest range
        send_sample(1'b0, 13'd46, 16'd1, 1'b0);      // just outside the sector
        send_sample(1'b0, 13'd359, 16'd0, 1'b0);     // zero range counts as infinite
        send_sample(1'b0, 13'd358, 16'd7, 1'b1);     // no echo counts as infinite
        send_sample(1'b0, 13'd315, 16'd1, 1'b0);     // bottom edge of sector
        send_sample(1'b0, 13'h1FFF, 16'd3, 1'b0);    // still past 360 after one wrap
        send_read(1'b0, 7'd45);
        send_read(1'b0, BIN_LAST);
        send_read(1'b0, 7'd44);
        send_read(1'b0, 7'd43);
        send_read(1'b0, 7'd0);
        send_read(1'b0, 7'd1);                       // never hit, reads empty
        send_read(1'b0, 7'h7F);                      // bin index past the table
        send_read(1'b1, 7'd45);                      // clear on a read

        // Just below 359.5 with a tiny step: rounds to 359, then wraps to 0 degrees.
        write_reg(CFG_ANGLE_START, START_W'(23560191));
        write_reg(CFG_ANGLE_STEP, START_W'(1));
        send_sample(1'b0, 13'd0, 16'd10, 1'b0);
        send_sample(1'b0, 13'd1, 16'd20, 1'b0);
        send_sample(1'b0, 13'h1FFF, 16'd5, 1'b0);
        send_read(1'b0, 7'd44);
        send_read(1'b0, 7'd45);

        // 44.5 rounds up into the 45 bin, 45.5 falls off the sector.
        write_reg(CFG_ANGLE_START, START_W'(2916352));
        write_reg(CFG_ANGLE_STEP, START_W'(32768));
        send_sample(1'b1, 13'd0, 16'd9, 1'b0);
        send_sample(1'b0, 13'd1, 16'd8, 1'b0);
        send_sample(1'b0, 13'd2, 16'd1, 1'b0);
        send_read(1'b0, BIN_LAST);

        // Random part: one configuration per phase, extremes first.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    start_val = 0;
                    step_val  = 65536;
                end
                1:
                begin
                    start_val = -23592960;
                    step_val  = 1048576;
                end
                2:
                begin
                    start_val = 23592960;
                    step_val  = 0;
                end
                3:
                begin
                    start_val = 20643840;
                    step_val  = 16384;
                end
                4:
                begin
                    start_val = -2949120;
                    step_val  = 65536;
                end
                5:
                begin
                    start_val = 23560192;
                    step_val  = 4096;
                end
                6:
                begin
                    start_val = int'($urandom_range(0, 47185920)) - 23592960;
                    step_val  = $urandom_range(0, 1048576);
                end
                default:
                begin
                    start_val = int'($urandom_range(0, 47185920)) - 23592960;
                    step_val  = $urandom_range(0, 8192);
                end
            endcase
            write_reg(CFG_ANGLE_START, START_W'(start_val));
            write_reg(CFG_ANGLE_STEP, START_W'(step_val));

            // keep one phase free of gaps, one with gaps on both sides
            if (p == 0)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            else if (p == 4)
            begin
                tx_idle = 1'b1;
                rx_idle = 1'b1;
            end
            else
            begin
                tx_idle = 1'($urandom_range(0, 1));
                rx_idle = 1'($urandom_range(0, 1));
            end

            // back up the result side while items keep coming
            if (p == 1)
                holds_asked++;

            // index span that sweeps a little past a full turn
            span = (step_val == 0) ? 8191 : (420 * 65536) / step_val;
            if (span > 8191)
                span = 8191;
            scan_pos = 0;
            new_scan = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                fos  = ($urandom_range(0, 49) == 0);
                if (pick < 55)
                begin
                    // scan-shaped samples: rising index, clear at the start of each sweep
                    case ($urandom_range(0, 9))
                        0:       rng = '0;
                        1:       rng = '1;
                        2, 3, 4: rng = RANGE_W'($urandom_range(1, 2000));
                        default: rng = RANGE_W'($urandom);
                    endcase
                    send_item(CMD_SAMPLE, fos | new_scan, IDX_W'(scan_pos), rng,
                              ($urandom_range(0, 9) == 0), BIN_W'($urandom));
                    new_scan = 1'b0;
                    scan_pos = scan_pos + $urandom_range(1, 1 + span / 40);
                    if (scan_pos > span)
                    begin
                        scan_pos = 0;
                        new_scan = 1'b1;
                    end
                end
                else if (pick < 85)
                begin
                    bin_sel = ($urandom_range(0, 9) == 0) ? BIN_W'($urandom_range(91, 127))
                                                          : BIN_W'($urandom_range(0, 90));
                    send_item(CMD_READ, fos, IDX_W'($urandom), RANGE_W'($urandom),
                              1'($urandom), bin_sel);
                end
                else
                    // noise: every field drawn over its full width
                    send_item(1'($urandom), fos, IDX_W'($urandom), RANGE_W'($urandom),
                              1'($urandom), BIN_W'($urandom));
            end
        end

        wait_idle();
        if (error_count == 0 && reports_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
